### src/dtdrm_pkg.sv
package dtdrm_pkg;

    // field widths
    localparam int CNT_W      = 16;
    localparam int CPM_W      = 22;
    localparam int EMA_W      = 24;
    localparam int GAIN_W     = 24;
    localparam int DOSE_W     = 38;
    localparam int ACC_W      = 64;
    localparam int TOT_W      = 53;
    localparam int UP_W       = 32;
    localparam int THR_W      = 32;

    // stream words
    localparam int IN_W       = 2 * CNT_W;
    localparam int OUT_W      = 2 * CPM_W + 2 * EMA_W + 2 * DOSE_W + TOT_W + UP_W + 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_ONE  = 2'd0,
        REG_GAIN_TWO  = 2'd1,
        REG_ALARM_THR = 2'd2
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(95870);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(65536);

    // count window
    localparam int WIN_LEN    = 60;
    localparam int POS_W      = $clog2(WIN_LEN);

    // smoothing weights, Q.8
    localparam int EMA_KEEP   = 179;
    localparam int EMA_TAKE   = 77;
    localparam int EMA_K_W    = 8;

    // radix-4 division by seconds per hour
    localparam int SEC_PER_HOUR = 3600;
    localparam int REM_W      = $clog2(SEC_PER_HOUR);
    localparam int DIG_W      = 2;
    localparam int TRY_W      = REM_W + DIG_W;
    localparam int DIV_STEPS  = ACC_W / DIG_W;

    // shift-add multiplier handles one cpm bit per cycle
    localparam int MUL_STEPS  = CPM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctl;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UPD  = 6'b000010,
        S_MUL  = 6'b000100,
        S_ACC  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

endpackage

### src/dual_tube_dose_rate_meter.sv
// one input word at a time: a new word is accepted only in idle, after the
//   previous result has gone to the output register; each word passes through
//   the bit-serial cpm x gain multipliers and the radix-4 divide by 3600
// reset (i_rst_n low at a clock edge) clears window, sums, averages, dose
//   total, uptime and alarm, and loads gains and threshold with defaults
module dual_tube_dose_rate_meter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side: count_one [15:0], count_two [31:16]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dtdrm_pkg::IN_W-1:0]       s_axis_tdata,
    // master side: cpm_one [21:0], cpm_two [43:22], smooth_rate_one [67:44],
    // smooth_rate_two [91:68], dose_rate_one [129:92], dose_rate_two [167:130],
    // total_dose [220:168], uptime_seconds [252:221], activity [253],
    // alarm_active [254], alarm_onset [255]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dtdrm_pkg::OUT_W-1:0]      m_axis_tdata,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dtdrm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtdrm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dtdrm_pkg::*;

    // sequencer
    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    // configuration registers
    logic [GAIN_W-1:0] r_gain_one;
    logic [GAIN_W-1:0] r_gain_two;
    logic [THR_W-1:0]  r_thr;

    // latched counts of the current word
    logic [CNT_W-1:0]  r_c1;
    logic [CNT_W-1:0]  r_c2;

    // window ring: both tubes share one memory word per second
    logic [IN_W-1:0]   r_mem [WIN_LEN];
    logic [IN_W-1:0]   r_rd_data;
    logic [WIN_LEN-1:0] r_vld;
    logic              r_old_vld;
    logic [POS_W-1:0]  r_pos;
    logic              w_we;

    // running state
    logic [CPM_W-1:0]  r_sum1;
    logic [CPM_W-1:0]  r_sum2;
    logic [CPM_W-1:0]  n_sum1;
    logic [CPM_W-1:0]  n_sum2;
    logic [EMA_W-1:0]  r_ema1;
    logic [EMA_W-1:0]  r_ema2;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [UP_W-1:0]   r_uptime;
    logic              r_alarm;
    logic              r_onset;
    logic              r_activity;

    logic [CNT_W-1:0]  w_old1;
    logic [CNT_W-1:0]  w_old2;
    logic [EMA_W-1:0]  w_ema1;
    logic [EMA_W-1:0]  w_ema2;
    logic [ACC_W:0]    w_acc_sum;
    logic              w_over;

    // serial units
    t_ser_ctl          w_mul_ctl;
    t_ser_ctl          w_div_ctl;
    logic [DOSE_W-1:0] w_dose1;
    logic [DOSE_W-1:0] w_dose2;
    logic [TOT_W-1:0]  w_total;

    // output word register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              w_in_acc;
    logic              w_out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // result can leave the pipe once the output register is free or draining
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_MUL;
                n_step  = '0;
            end
            S_MUL: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_ACC;
                    n_step  = '0;
                end
            end
            S_ACC: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                    n_step  = '0;
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // ---------------------------------------------------------------
    // configuration writes, unknown indexes fall through
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_one <= GAIN_RESET;
            r_gain_two <= GAIN_RESET;
            r_thr      <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_GAIN_ONE:  r_gain_one <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_TWO:  r_gain_two <= i_cfg_data[GAIN_W-1:0];
                REG_ALARM_THR: r_thr      <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input latch
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_c1 <= s_axis_tdata[CNT_W-1:0];
            r_c2 <= s_axis_tdata[IN_W-1:CNT_W];
        end
    end

    // ---------------------------------------------------------------
    // window ring; the oldest entry sits at r_pos and is read every cycle,
    // so it is already registered when the update runs
    // ---------------------------------------------------------------
    assign w_we = (r_state == S_UPD);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pos] <= {r_c2, r_c1};
        end
        r_rd_data <= r_mem[r_pos];
        r_old_vld <= r_vld[r_pos];
    end

    // entries never written count as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_pos <= '0;
        end else if (w_we) begin
            r_vld[r_pos] <= 1'b1;
            r_pos        <= (r_pos == POS_W'(WIN_LEN - 1)) ? '0 : r_pos + 1'b1;
        end
    end

    assign w_old1 = r_old_vld ? r_rd_data[CNT_W-1:0]    : '0;
    assign w_old2 = r_old_vld ? r_rd_data[IN_W-1:CNT_W] : '0;

    // oldest count leaves as the new one enters
    assign n_sum1 = r_sum1 - CPM_W'(w_old1) + CPM_W'(r_c1);
    assign n_sum2 = r_sum2 - CPM_W'(w_old2) + CPM_W'(r_c2);

    // ema = (ema*179 + (c<<8)*77) >> 8; the count term has no fraction bits
    assign w_ema1 = EMA_W'(((EMA_W + EMA_K_W)'(r_ema1)
                            * (EMA_W + EMA_K_W)'(EMA_KEEP)) >> 8)
                  + EMA_W'(r_c1) * EMA_W'(EMA_TAKE);
    assign w_ema2 = EMA_W'(((EMA_W + EMA_K_W)'(r_ema2)
                            * (EMA_W + EMA_K_W)'(EMA_KEEP)) >> 8)
                  + EMA_W'(r_c2) * EMA_W'(EMA_TAKE);

    // saturating dose accumulator
    assign w_acc_sum = {1'b0, r_acc} + (ACC_W + 1)'(w_dose1);
    assign w_over    = w_acc_sum[ACC_W];
    assign n_acc     = w_over ? '1 : w_acc_sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum1   <= '0;
            r_sum2   <= '0;
            r_ema1   <= '0;
            r_ema2   <= '0;
            r_acc    <= '0;
            r_uptime <= '0;
            r_alarm  <= 1'b0;
        end else begin
            if (r_state == S_UPD) begin
                r_sum1   <= n_sum1;
                r_sum2   <= n_sum2;
                r_ema1   <= w_ema1;
                r_ema2   <= w_ema2;
                r_uptime <= r_uptime + 1'b1;
            end
            if (r_state == S_ACC) begin
                r_acc   <= n_acc;
                r_alarm <= (w_dose1 > DOSE_W'(r_thr));
            end
        end
    end

    // per-word flags, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_activity <= (r_c1 != '0) || (r_c2 != '0);
        end
        if (r_state == S_ACC) begin
            r_onset <= (w_dose1 > DOSE_W'(r_thr)) && !r_alarm;
        end
    end

    // ---------------------------------------------------------------
    // serial units: multipliers load with the new window sums,
    // divider loads with the new accumulator
    // ---------------------------------------------------------------
    assign w_mul_ctl.load = (r_state == S_UPD);
    assign w_mul_ctl.step = (r_state == S_MUL);
    assign w_div_ctl.load = (r_state == S_ACC);
    assign w_div_ctl.step = (r_state == S_DIV);

    dtdrm_smul u_mul_one (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_cpm  (n_sum1),
        .i_gain (r_gain_one),
        .o_dose (w_dose1)
    );

    dtdrm_smul u_mul_two (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_cpm  (n_sum2),
        .i_gain (r_gain_two),
        .o_dose (w_dose2)
    );

    dtdrm_sdiv u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_dividend (n_acc),
        .o_quotient (w_total)
    );

    // ---------------------------------------------------------------
    // output word register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {r_onset, r_alarm, r_activity, r_uptime, w_total,
                           w_dose2, w_dose1, r_ema2, r_ema1, r_sum2, r_sum1};
        end
    end

endmodule

### src/dtdrm_smul.sv
module dtdrm_smul (
    input  logic                         i_clk,
    input  dtdrm_pkg::t_ser_ctl          i_ctl,
    input  logic [dtdrm_pkg::CPM_W-1:0]  i_cpm,
    input  logic [dtdrm_pkg::GAIN_W-1:0] i_gain,
    output logic [dtdrm_pkg::DOSE_W-1:0] o_dose
);
    import dtdrm_pkg::*;

    // {r_hi, r_lo} holds partial product over remaining multiplier bits
    logic [GAIN_W-1:0] r_hi;
    logic [CPM_W-1:0]  r_lo;
    logic [GAIN_W:0]   w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, i_gain} : '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hi <= '0;
            r_lo <= i_cpm;
        end else if (i_ctl.step) begin
            r_hi <= w_sum[GAIN_W:1];
            r_lo <= {w_sum[0], r_lo[CPM_W-1:1]};
        end
    end

    // product >> 8
    assign o_dose = {r_hi, r_lo[CPM_W-1:8]};

endmodule

### src/dtdrm_sdiv.sv
module dtdrm_sdiv (
    input  logic                        i_clk,
    input  dtdrm_pkg::t_ser_ctl         i_ctl,
    input  logic [dtdrm_pkg::ACC_W-1:0] i_dividend,
    output logic [dtdrm_pkg::TOT_W-1:0] o_quotient
);
    import dtdrm_pkg::*;

    localparam logic [TRY_W-1:0] D1 = TRY_W'(SEC_PER_HOUR);
    localparam logic [TRY_W-1:0] D2 = TRY_W'(2 * SEC_PER_HOUR);
    localparam logic [TRY_W-1:0] D3 = TRY_W'(3 * SEC_PER_HOUR);

    // dividend shifts out at the top while quotient digits shift in below
    logic [ACC_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [TRY_W-1:0] w_try;
    logic [TRY_W-1:0] w_diff;
    logic [DIG_W-1:0] w_dig;

    assign w_try = {r_rem, r_quo[ACC_W-1 -: DIG_W]};

    always_comb begin
        if (w_try >= D3) begin
            w_dig  = 2'd3;
            w_diff = w_try - D3;
        end else if (w_try >= D2) begin
            w_dig  = 2'd2;
            w_diff = w_try - D2;
        end else if (w_try >= D1) begin
            w_dig  = 2'd1;
            w_diff = w_try - D1;
        end else begin
            w_dig  = 2'd0;
            w_diff = w_try;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_quo <= {r_quo[ACC_W-DIG_W-1:0], w_dig};
            r_rem <= w_diff[REM_W-1:0];
        end
    end

    assign o_quotient = r_quo[TOT_W-1:0];

endmodule
